// File: rtl/core/svp_pkg.sv
// Shared types, constants and helpers of the sphere voxel painter.
// Depends on nothing; the front end, queue, back end and top level import it.
package svp_pkg;

  localparam int IDX_W     = 9;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 21;
  localparam int RECIP_W   = 31;
  localparam int RAD_W     = 21;
  localparam int R2_W      = 40;
  localparam int VOX_W     = 6;
  localparam int SAT_W     = 22;
  localparam int SQ_W      = 44;
  localparam int REG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [SAT_W-1:0] AXIS_SAT = SAT_W'(1 << 21);

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_STEP     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GRID_RECIP    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_STATUS = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_EPS    = 3'd6;

  localparam logic CMD_PAINT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [STEP_W-1:0]         step;
    logic [RECIP_W-1:0]        recip;
    logic                      en_status;
    logic                      en_eps;
  } cfg_t;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [R2_W-1:0]           r2;
    logic [2:0][IDX_W-1:0]     lo;
    logic [2:0][IDX_W-1:0]     hi;
    logic                      oob;
  } item_t;

  typedef struct packed {
    logic valid;
    logic centre;
    logic eps_x;
    logic eps_y;
    logic eps_z;
  } res_t;

  function automatic logic [SAT_W-1:0] sat_abs(input logic signed [35:0] d);
    logic [35:0] a;
    a = d[35] ? 36'(-d) : 36'(d);
    if (a > 36'(AXIS_SAT)) begin
      return AXIS_SAT;
    end
    return a[SAT_W-1:0];
  endfunction

endpackage

// File: rtl/core/svp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module svp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/svp_front.sv
// Front end: takes requests and turns each sphere box into clamped voxel indices.
// Uses svp_pkg; feeds svp_queue.
module svp_front #(
  parameter int GRID_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          command,
  input  logic signed [svp_pkg::COORD_W-1:0] center_x,
  input  logic signed [svp_pkg::COORD_W-1:0] center_y,
  input  logic signed [svp_pkg::COORD_W-1:0] center_z,
  input  logic [svp_pkg::RAD_W-1:0]     radius,
  input  logic [svp_pkg::R2_W-1:0]      radius_squared,
  input  logic [svp_pkg::VOX_W-1:0]     voxel_x,
  input  logic [svp_pkg::VOX_W-1:0]     voxel_y,
  input  logic [svp_pkg::VOX_W-1:0]     voxel_z,
  input  svp_pkg::cfg_t                 cfg,
  input  logic                          full,
  output logic                          push,
  output svp_pkg::item_t                item,
  output logic                          busy
);
  import svp_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SUB  = 5'b00010,
    F_MUL  = 5'b00100,
    F_SUM  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t            state;
  item_t              it;
  logic [RAD_W-1:0]   rad;
  logic [2:0]         k;
  logic signed [33:0] d_q;
  logic [47:0]        lo_q;
  logic [46:0]        hi_q;
  logic               neg_q;

  logic [1:0]                axis;
  logic signed [COORD_W-1:0] c_sel;
  logic signed [COORD_W-1:0] o_sel;
  logic signed [33:0]        coord;
  logic [64:0]               rnd;
  logic [32:0]               q;
  logic [IDX_W-1:0]          idx;

  assign axis = k[2:1];
  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !full;
  assign item = it;

  always_comb begin
    unique case (axis)
      2'd0: begin
        c_sel = it.cx;
        o_sel = cfg.origin_x;
      end
      2'd1: begin
        c_sel = it.cy;
        o_sel = cfg.origin_y;
      end
      default: begin
        c_sel = it.cz;
        o_sel = cfg.origin_z;
      end
    endcase
    coord = k[0] ? 34'(c_sel) + 34'(rad) : 34'(c_sel) - 34'(rad);
    rnd   = 65'(lo_q) + (65'(hi_q) << 17) + (65'd1 << 31);
    q     = rnd[64:32];
    if (neg_q) begin
      idx = '0;
    end else if (q > 33'(GRID_DIM - 1)) begin
      idx = IDX_W'(GRID_DIM - 1);
    end else begin
      idx = IDX_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= (command == CMD_READ) ? F_PUSH : F_SUB;
        F_SUB:  state <= F_MUL;
        F_MUL:  state <= F_SUM;
        F_SUM:  state <= (k == 3'd5) ? F_PUSH : F_SUB;
        F_PUSH: if (!full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      it.cmd   <= command;
      it.cx    <= center_x;
      it.cy    <= center_y;
      it.cz    <= center_z;
      it.r2    <= radius_squared;
      it.lo[0] <= IDX_W'(voxel_x);
      it.lo[1] <= IDX_W'(voxel_y);
      it.lo[2] <= IDX_W'(voxel_z);
      it.oob   <= (32'(voxel_x) >= 32'(GRID_DIM)) || (32'(voxel_y) >= 32'(GRID_DIM)) ||
                  (32'(voxel_z) >= 32'(GRID_DIM));
      rad      <= radius;
      k        <= '0;
    end
    if (state == F_SUB) begin
      d_q <= coord - 34'(o_sel);
    end
    if (state == F_MUL) begin
      neg_q <= d_q[33];
      lo_q  <= 48'(d_q[16:0]) * 48'(cfg.recip);
      hi_q  <= 47'(d_q[32:17]) * 47'(cfg.recip);
    end
    if (state == F_SUM) begin
      if (k[0]) begin
        it.hi[axis] <= idx;
      end else begin
        it.lo[axis] <= idx;
      end
      k <= k + 3'd1;
    end
  end
endmodule

// File: rtl/core/svp_queue.sv
// Two-entry request queue between the front and back ends.
// Uses svp_pkg.
module svp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  svp_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output svp_pkg::item_t dout,
  output logic           empty
);
  import svp_pkg::*;

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end
endmodule

// File: rtl/core/svp_back.sv
// Back end: clears the voxel store, walks sphere boxes through the test
// pipeline with read-modify-write, and serves voxel reads. Uses svp_pkg, svp_ram.
module svp_back #(
  parameter int GRID_DIM = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  svp_pkg::cfg_t  cfg,
  input  svp_pkg::item_t item,
  input  logic           empty,
  output logic           pop,
  output logic           clearing,
  output svp_pkg::res_t  res
);
  import svp_pkg::*;

  localparam int IW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int AW    = 3 * IW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_WALK  = 5'b00100,
    B_DRAIN = 5'b01000,
    B_READ  = 5'b10000
  } bstate_t;

  bstate_t state;
  item_t   cur;
  logic [AW-1:0] clr_addr;
  logic [IW-1:0] ix, iy, iz;
  logic [IW-1:0] x0, x1, y0, y1, z1;
  logic          last;
  logic          empty_box;

  logic                 s1_v, s2_v, s3_v, s4_v;
  logic signed [33:0]   s1_p [3];
  logic [AW-1:0]        s1_addr, s2_addr, s3_addr, s4_addr;
  logic [SAT_W-1:0]     s2_a [6];
  logic [SQ_W-1:0]      s3_sq [6];
  logic [SQ_W-1:0]      s4_sq [6];

  logic [IW+STEP_W-1:0] mx, my, mz;
  logic signed [35:0]   dd [6];
  logic [SQ_W-1:0]      sum_c, sum_x, sum_y, sum_z;
  logic [3:0]           hit;
  logic [3:0]           rdata;
  logic [3:0]           wdata;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic                 we;

  assign clearing  = (state == B_CLEAR);
  assign pop       = (state == B_IDLE) && !empty;
  assign last      = (ix == x1) && (iy == y1) && (iz == z1);
  assign empty_box = (IW'(item.lo[0]) > IW'(item.hi[0])) ||
                     (IW'(item.lo[1]) > IW'(item.hi[1])) ||
                     (IW'(item.lo[2]) > IW'(item.hi[2]));

  always_comb begin
    mx    = ix * cfg.step;
    my    = iy * cfg.step;
    mz    = iz * cfg.step;
    dd[0] = 36'(s1_p[0]) - 36'(cur.cx);
    dd[1] = 36'(s1_p[0]) + 36'(cfg.step[STEP_W-1:1]) - 36'(cur.cx);
    dd[2] = 36'(s1_p[1]) - 36'(cur.cy);
    dd[3] = 36'(s1_p[1]) + 36'(cfg.step[STEP_W-1:1]) - 36'(cur.cy);
    dd[4] = 36'(s1_p[2]) - 36'(cur.cz);
    dd[5] = 36'(s1_p[2]) + 36'(cfg.step[STEP_W-1:1]) - 36'(cur.cz);
    sum_c = s4_sq[0] + s4_sq[2] + s4_sq[4];
    sum_x = s4_sq[1] + s4_sq[2] + s4_sq[4];
    sum_y = s4_sq[0] + s4_sq[3] + s4_sq[4];
    sum_z = s4_sq[0] + s4_sq[2] + s4_sq[5];
    hit[0] = cfg.en_status && (sum_c < SQ_W'(cur.r2));
    hit[1] = cfg.en_eps && (sum_x < SQ_W'(cur.r2));
    hit[2] = cfg.en_eps && (sum_y < SQ_W'(cur.r2));
    hit[3] = cfg.en_eps && (sum_z < SQ_W'(cur.r2));
    raddr = (state == B_IDLE) ?
            {IW'(item.lo[2]), IW'(item.lo[1]), IW'(item.lo[0])} : s3_addr;
    we    = clearing || s4_v;
    waddr = clearing ? clr_addr : s4_addr;
    wdata = clearing ? 4'b0000 : (rdata | hit);
  end

  svp_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      s4_v     <= 1'b0;
      res      <= '0;
    end else begin
      s1_v      <= (state == B_WALK);
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      res.valid <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!empty) begin
            if (item.cmd == CMD_READ) begin
              state <= B_READ;
            end else if (!empty_box) begin
              state <= B_WALK;
            end
          end
        end
        B_WALK: if (last) state <= B_DRAIN;
        B_DRAIN: if (!(s1_v || s2_v || s3_v || s4_v)) state <= B_IDLE;
        B_READ: begin
          res.valid  <= 1'b1;
          res.centre <= !cur.oob && rdata[0];
          res.eps_x  <= !cur.oob && rdata[1];
          res.eps_y  <= !cur.oob && rdata[2];
          res.eps_z  <= !cur.oob && rdata[3];
          state      <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= item;
      x0  <= IW'(item.lo[0]);
      x1  <= IW'(item.hi[0]);
      y0  <= IW'(item.lo[1]);
      y1  <= IW'(item.hi[1]);
      z1  <= IW'(item.hi[2]);
      ix  <= IW'(item.lo[0]);
      iy  <= IW'(item.lo[1]);
      iz  <= IW'(item.lo[2]);
    end else if (state == B_WALK) begin
      if (ix == x1) begin
        ix <= x0;
        if (iy == y1) begin
          iy <= y0;
          iz <= iz + IW'(1);
        end else begin
          iy <= iy + IW'(1);
        end
      end else begin
        ix <= ix + IW'(1);
      end
    end
    s1_p[0] <= 34'(cfg.origin_x) + 34'(mx);
    s1_p[1] <= 34'(cfg.origin_y) + 34'(my);
    s1_p[2] <= 34'(cfg.origin_z) + 34'(mz);
    s1_addr <= {iz, iy, ix};
    s2_addr <= s1_addr;
    s3_addr <= s2_addr;
    s4_addr <= s3_addr;
    for (int i = 0; i < 6; i++) begin
      s2_a[i]  <= sat_abs(dd[i]);
      s3_sq[i] <= SQ_W'(s2_a[i]) * SQ_W'(s2_a[i]);
      s4_sq[i] <= s3_sq[i];
    end
  end
endmodule

// File: rtl/core/sphere_voxel_painter_unit.sv
// Sphere voxel painter top level: configuration registers, front end, queue, back end.
// Read: the front end pushes the request to the queue; the back end pops it, reads the store and strobes the result.
// Paint: the front end computes six indices (subtract, multiply, sum each), then the queue push; the
// back end then walks one voxel per cycle, pops and drains its pipeline, so box volume sets rate.
// After reset the voxel store is swept clear, one entry per cycle, all 2^(3*ceil(log2
// GRID_DIM)) entries with busy high. Results cannot be stalled. Uses svp_pkg.
module sphere_voxel_painter_unit #(
  parameter int GRID_DIM = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_write,
  input  logic [svp_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [svp_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               command,
  input  logic signed [svp_pkg::COORD_W-1:0] center_x,
  input  logic signed [svp_pkg::COORD_W-1:0] center_y,
  input  logic signed [svp_pkg::COORD_W-1:0] center_z,
  input  logic [svp_pkg::RAD_W-1:0]          radius,
  input  logic [svp_pkg::R2_W-1:0]           radius_squared,
  input  logic [svp_pkg::VOX_W-1:0]          voxel_x,
  input  logic [svp_pkg::VOX_W-1:0]          voxel_y,
  input  logic [svp_pkg::VOX_W-1:0]          voxel_z,
  output logic                               result_valid,
  output logic                               centre_inside,
  output logic                               eps_inside_x,
  output logic                               eps_inside_y,
  output logic                               eps_inside_z
);
  import svp_pkg::*;

  cfg_t  cfg;
  item_t f_item;
  item_t q_item;
  res_t  res;
  logic  f_busy, clearing, accept;
  logic  push, full, pop, empty;

  assign busy          = f_busy || clearing;
  assign accept        = start && !busy;
  assign result_valid  = res.valid;
  assign centre_inside = res.centre;
  assign eps_inside_x  = res.eps_x;
  assign eps_inside_y  = res.eps_y;
  assign eps_inside_z  = res.eps_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x  <= '0;
      cfg.origin_y  <= '0;
      cfg.origin_z  <= '0;
      cfg.step      <= STEP_W'(65536);
      cfg.recip     <= RECIP_W'(65536);
      cfg.en_status <= 1'b1;
      cfg.en_eps    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      cfg.origin_x  <= cfg_data;
        REG_ORIGIN_Y:      cfg.origin_y  <= cfg_data;
        REG_ORIGIN_Z:      cfg.origin_z  <= cfg_data;
        REG_GRID_STEP:     cfg.step      <= cfg_data[STEP_W-1:0];
        REG_GRID_RECIP:    cfg.recip     <= cfg_data[RECIP_W-1:0];
        REG_ENABLE_STATUS: cfg.en_status <= cfg_data[0];
        REG_ENABLE_EPS:    cfg.en_eps    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  svp_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (command),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .radius        (radius),
    .radius_squared(radius_squared),
    .voxel_x       (voxel_x),
    .voxel_y       (voxel_y),
    .voxel_z       (voxel_z),
    .cfg           (cfg),
    .full          (full),
    .push          (push),
    .item          (f_item),
    .busy          (f_busy)
  );

  svp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (f_item),
    .full (full),
    .pop  (pop),
    .dout (q_item),
    .empty(empty)
  );

  svp_back #(.GRID_DIM(GRID_DIM)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (q_item),
    .empty   (empty),
    .pop     (pop),
    .clearing(clearing),
    .res     (res)
  );
endmodule

// File: rtl/core/svp_checker.sv
// Port-level checks for the sphere voxel painter, bound to the top level.
// Sees only the top-level handshake ports.
module svp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy low after accepted request");

  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> (busy && !result_valid)) else $error("not clearing after reset");

  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("result strobe longer than one cycle");

  a_known_status: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({busy, result_valid})) else $error("busy or result strobe unknown");
endmodule

bind sphere_voxel_painter_unit svp_checker u_svp_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid)
);
